// ----- hdl/utf8_stream_decoder_core_assert.svh -----
// Assertion macros shared by the decoder modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef UTF8_STREAM_DECODER_CORE_ASSERT_SVH
`define UTF8_STREAM_DECODER_CORE_ASSERT_SVH

// Same-cycle implication.
`define U8D_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define U8D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/u8d_pkg.sv -----
package u8d_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_QMARK = 2'd1;
  localparam logic [1:0] ST_FFFD  = 2'd2;

  localparam logic [CpW-1:0] CP_QMARK   = 21'h00003f;
  localparam logic [CpW-1:0] CP_FFFD    = 21'h00fffd;
  localparam logic [CpW-1:0] CP_3MIN    = 21'h000800;
  localparam logic [CpW-1:0] CP_SURR_LO = 21'h00d800;
  localparam logic [CpW-1:0] CP_SURR_HI = 21'h00dfff;
  localparam logic [CpW-1:0] CP_4MIN    = 21'h010000;
  localparam logic [CpW-1:0] CP_4MAX    = 21'h10ffff;

  localparam logic [7:0] LEAD2_MIN = 8'hc2;

  typedef enum logic [1:0] {
    SEL_DIRECT,
    SEL_QMARK,
    SEL_FFFD,
    SEL_TAIL
  } res_sel_t;

  // Controller to datapath.
  typedef struct packed {
    logic     take;
    logic     load;
    res_sel_t sel;
    logic     last;
    logic     rep_dec;
    logic     tail;
  } u8d_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic       out_free;
    logic       err;
    logic       direct_res;
    logic [1:0] rep_in;
    logic       tail_res_in;
    logic [1:0] rep_cnt;
    logic       tail_res_r;
  } u8d_sts_t;

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  // Number of continuation bytes a lead byte asks for, zero if not a lead.
  function automatic logic [1:0] lead_need(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if (b[7:5] == 3'b110) n = 2'd1;
    else if (b[7:4] == 4'b1110) n = 2'd2;
    else if (b[7:3] == 5'b11110) n = 2'd3;
    return n;
  endfunction

  function automatic logic is_lead(input logic [7:0] b);
    return lead_need(b) != 2'd0;
  endfunction

  // A byte decoded on its own with nothing pending yields a result unless it
  // is a terminator or a lead that starts a new sequence.
  function automatic logic byte_has_res(input logic [7:0] b);
    return (b != 8'h00) && !is_lead(b);
  endfunction

  function automatic logic [CpW-1:0] byte_cp(input logic [7:0] b);
    return b[7] ? CP_FFFD : {{(CpW-8){1'b0}}, b};
  endfunction

  function automatic logic [1:0] byte_st(input logic [7:0] b);
    return b[7] ? ST_FFFD : ST_OK;
  endfunction

endpackage

// ----- hdl/utf8_stream_decoder_core.sv -----
// UTF-8 stream decoder: one byte in, zero to four code points out.
// Input channel: in_data_byte with in_valid / in_ready. A zero byte ends the
// string and flushes any open sequence; it never produces a result itself.
// Output channel: out_code_point, out_status (0 ok, 1 '?', 2 U+FFFD) and
// out_last with out_valid / out_ready; out_last marks the final result of a byte.
// A result is registered: it appears in the output register in the cycle after
// the byte that completes it is accepted.
// Throughput: well-formed text takes one byte per cycle while the output is not
// stalled. A broken sequence puts out '?', a stray U+FFFD for each of the N held
// continuation bytes (0 to 2) and the new byte's result, if any, one per unstalled
// cycle through the single result register; the input is not ready meanwhile.
// Reset (synchronous, active low) drops any pending sequence and any result
// not yet taken.
// A stall on out_ready holds the current result; one more byte can be taken
// in the cycle the held result is accepted, so a stall stops the input as well.
module utf8_stream_decoder_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_data_byte,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [u8d_pkg::CpW-1:0] out_code_point,
  output logic [1:0]              out_status,
  output logic                    out_last
);
  import u8d_pkg::*;

  u8d_cmd_t cmd;
  u8d_sts_t sts;

  u8d_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  u8d_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_data_byte   (in_data_byte),
    .out_ready      (out_ready),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_code_point (out_code_point),
    .out_status     (out_status),
    .out_last       (out_last)
  );

endmodule

// ----- hdl/u8d_datapath.sv -----
`include "utf8_stream_decoder_core_assert.svh"

module u8d_datapath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [7:0]              in_data_byte,
  input  logic                    out_ready,
  input  u8d_pkg::u8d_cmd_t       cmd,
  output u8d_pkg::u8d_sts_t       sts,
  output logic                    out_valid,
  output logic [u8d_pkg::CpW-1:0] out_code_point,
  output logic [1:0]              out_status,
  output logic                    out_last
);
  import u8d_pkg::*;

  logic [7:0]     held_r   [3];
  logic [7:0]     held_nxt [3];
  logic [1:0]     hcnt_r, hcnt_nxt;
  logic [1:0]     rep_r, rep_nxt;
  logic [7:0]     byte_r, byte_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [CpW-1:0] cp_r, cp_nxt;
  logic [1:0]     st_r, st_nxt;
  logic           last_r, last_nxt;

  logic [7:0]     lead;
  logic [1:0]     need;
  logic           flush;
  logic           err;
  logic           complete;
  logic [10:0]    cp2;
  logic [15:0]    cp3;
  logic [CpW-1:0] cp3_w;
  logic [CpW-1:0] cp4;
  logic [CpW-1:0] dir_cp;
  logic [1:0]     dir_st;

  assign lead  = held_r[0];
  assign need  = lead_need(lead);
  assign flush = in_data_byte == 8'h00;

  // A pending sequence breaks on a terminator, on a byte that is not a
  // continuation, or when the two-byte lead would give an overlong form.
  assign err = (hcnt_r != 2'd0) &&
               (flush || !is_cont(in_data_byte) ||
                ((need == 2'd1) && (lead < LEAD2_MIN)));
  assign complete = (hcnt_r != 2'd0) && (hcnt_r == need);

  assign cp2   = {lead[4:0], in_data_byte[5:0]};
  assign cp3   = {lead[3:0], held_r[1][5:0], in_data_byte[5:0]};
  assign cp3_w = {{(CpW-16){1'b0}}, cp3};
  assign cp4   = {lead[2:0], held_r[1][5:0], held_r[2][5:0], in_data_byte[5:0]};

  always_comb begin
    dir_cp = byte_cp(in_data_byte);
    dir_st = byte_st(in_data_byte);
    if (hcnt_r != 2'd0) begin
      case (need)
        2'd1: begin
          dir_cp = {{(CpW-11){1'b0}}, cp2};
          dir_st = ST_OK;
        end
        2'd2: begin
          if ((cp3_w < CP_3MIN) || ((cp3_w >= CP_SURR_LO) && (cp3_w <= CP_SURR_HI))) begin
            dir_cp = CP_QMARK;
            dir_st = ST_QMARK;
          end else begin
            dir_cp = cp3_w;
            dir_st = ST_OK;
          end
        end
        2'd3: begin
          if ((cp4 < CP_4MIN) || (cp4 > CP_4MAX)) begin
            dir_cp = CP_QMARK;
            dir_st = ST_QMARK;
          end else begin
            dir_cp = cp4;
            dir_st = ST_OK;
          end
        end
        default: begin
          dir_cp = CP_QMARK;
          dir_st = ST_QMARK;
        end
      endcase
    end
  end

  always_comb begin
    sts.out_free    = !out_valid_r || out_ready;
    sts.err         = err;
    sts.direct_res  = (hcnt_r == 2'd0) ? byte_has_res(in_data_byte) : complete;
    sts.rep_in      = hcnt_r - 2'd1;
    sts.tail_res_in = byte_has_res(in_data_byte);
    sts.rep_cnt     = rep_r;
    sts.tail_res_r  = byte_has_res(byte_r);
  end

  always_comb begin
    held_nxt = held_r;
    hcnt_nxt = hcnt_r;
    rep_nxt  = rep_r;
    byte_nxt = byte_r;
    if (cmd.take) begin
      byte_nxt = in_data_byte;
      if (err) begin
        // Drop the lead; the held continuations are replayed as strays.
        hcnt_nxt = 2'd0;
        rep_nxt  = hcnt_r - 2'd1;
      end else if (hcnt_r == 2'd0) begin
        if (is_lead(in_data_byte)) begin
          held_nxt[0] = in_data_byte;
          hcnt_nxt    = 2'd1;
        end
      end else if (complete) begin
        hcnt_nxt = 2'd0;
      end else begin
        held_nxt[hcnt_r] = in_data_byte;
        hcnt_nxt         = hcnt_r + 2'd1;
      end
    end
    if (cmd.rep_dec) begin
      rep_nxt = rep_r - 2'd1;
    end
    if (cmd.tail && is_lead(byte_r)) begin
      held_nxt[0] = byte_r;
      hcnt_nxt    = 2'd1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    cp_nxt        = cp_r;
    st_nxt        = st_r;
    last_nxt      = last_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
      last_nxt      = cmd.last;
      case (cmd.sel)
        SEL_DIRECT: begin
          cp_nxt = dir_cp;
          st_nxt = dir_st;
        end
        SEL_QMARK: begin
          cp_nxt = CP_QMARK;
          st_nxt = ST_QMARK;
        end
        SEL_FFFD: begin
          cp_nxt = CP_FFFD;
          st_nxt = ST_FFFD;
        end
        SEL_TAIL: begin
          cp_nxt = byte_cp(byte_r);
          st_nxt = byte_st(byte_r);
        end
        default: begin
          cp_nxt = CP_FFFD;
          st_nxt = ST_FFFD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r      <= 2'd0;
      rep_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      hcnt_r      <= hcnt_nxt;
      rep_r       <= rep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    byte_r <= byte_nxt;
    cp_r   <= cp_nxt;
    st_r   <= st_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = cp_r;
  assign out_status     = st_r;
  assign out_last       = last_r;

  `U8D_ASSERT(a_held_is_prefix, hcnt_r != 2'd0, is_lead(held_r[0]) && (hcnt_r <= lead_need(held_r[0])), "held bytes do not form an open sequence")
  `U8D_ASSERT(a_replay_nothing_held, rep_r != 2'd0, hcnt_r == 2'd0, "bytes held while replaying")
  `U8D_ASSERT(a_load_needs_room, cmd.load, !out_valid_r || out_ready, "result register overwritten")

endmodule

// ----- hdl/u8d_ctrl.sv -----
`include "utf8_stream_decoder_core_assert.svh"

module u8d_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  u8d_pkg::u8d_sts_t   sts,
  output u8d_pkg::u8d_cmd_t   cmd
);
  import u8d_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REPL,
    S_TAIL
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE) && sts.out_free;

  always_comb begin
    cmd       = '0;
    cmd.sel   = SEL_DIRECT;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && sts.out_free) begin
          cmd.take = 1'b1;
          if (sts.err) begin
            cmd.load  = 1'b1;
            cmd.sel   = SEL_QMARK;
            cmd.last  = (sts.rep_in == 2'd0) && !sts.tail_res_in;
            state_nxt = (sts.rep_in != 2'd0) ? S_REPL : S_TAIL;
          end else if (sts.direct_res) begin
            cmd.load = 1'b1;
            cmd.sel  = SEL_DIRECT;
            cmd.last = 1'b1;
          end
        end
      end
      S_REPL: begin
        if (sts.out_free) begin
          cmd.load    = 1'b1;
          cmd.sel     = SEL_FFFD;
          cmd.last    = (sts.rep_cnt == 2'd1) && !sts.tail_res_r;
          cmd.rep_dec = 1'b1;
          if (sts.rep_cnt == 2'd1) begin
            state_nxt = S_TAIL;
          end
        end
      end
      S_TAIL: begin
        if (!sts.tail_res_r) begin
          cmd.tail  = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.tail  = 1'b1;
          cmd.load  = 1'b1;
          cmd.sel   = SEL_TAIL;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `U8D_ASSERT_NEXT(a_err_leaves_idle, (state_r == S_IDLE) && cmd.take && sts.err, state_r != S_IDLE, "error sequence not started")
  `U8D_ASSERT(a_repl_has_count, state_r == S_REPL, sts.rep_cnt != 2'd0, "replay state with nothing to replay")
  `U8D_ASSERT(a_tail_after_repl, state_r == S_TAIL, sts.rep_cnt == 2'd0, "tail reached with replays left")

endmodule
